### hdl/bsbe_pkg.sv
// Package for the B-spline basis evaluator: fixed-point types, saturation helpers and codes.
// No dependencies; every other file of the block imports it, but for the port checks.
package bsbe_pkg;

    localparam int VW = 32;              // width of a fixed-point value
    localparam int FB = 16;              // fraction bits
    localparam int WW = 2 * VW + 2;      // wide intermediate width

    typedef logic signed [VW-1:0] fix_t;
    typedef logic signed [WW-1:0] wide_t;

    typedef struct packed {
        logic ovf;
        fix_t val;
    } sat_t;

    typedef struct packed {
        logic done;
        logic ovf;
        fix_t quo;
    } div_res_t;

    localparam fix_t FIX_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam fix_t FIX_ONE = fix_t'(64'd1 << FB);
    localparam wide_t HALF_W = wide_t'(64'd1 << (FB - 1));

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_DERIV = 2'd1;
    localparam logic [1:0] CFG_NBRK  = 2'd2;

    function automatic sat_t sat_wide(input wide_t v);
        sat_t s;
        if (v > wide_t'(FIX_MAX)) begin
            s.ovf = 1'b1;
            s.val = FIX_MAX;
        end else if (v < wide_t'(FIX_MIN)) begin
            s.ovf = 1'b1;
            s.val = FIX_MIN;
        end else begin
            s.ovf = 1'b0;
            s.val = fix_t'(v[VW-1:0]);
        end
        return s;
    endfunction

    function automatic sat_t fadd(input fix_t a, input fix_t b);
        return sat_wide(wide_t'(a) + wide_t'(b));
    endfunction

    function automatic sat_t fsub(input fix_t a, input fix_t b);
        return sat_wide(wide_t'(a) - wide_t'(b));
    endfunction

endpackage

### hdl/bspline_basis_evaluator_unit.sv
// Top level of the B-spline basis evaluator: break store, sequencer, multiplier and emission.
// Depends on bsbe_pkg and instantiates bsbe_div.
//
//  channel  | ports                       | word
//  ---------+-----------------------------+---------------------------------------------
//  input    | s_tvalid s_tready s_tdata   | tuser: cmd; tdata: break_index, value
//  result   | m_tvalid m_tready m_tdata   | tuser: overflow; tlast: last; tdata: index, value
//  config   | cfg_we cfg_addr cfg_wdata   | order, derivative order, break count
//
// A break write is taken in idle. A point first checks the last break and sets up, then
// steps the interval pointer, a read and a check per step, then works the basis triangle
// row by row and then each derivative step, reading knots and running one division per
// entry on the bit-serial divider; emission then sends k words, one per basis function.
// Reset is synchronous; the break store is not cleared. One point is worked on at a time;
// a stalled result channel holds the sequencer in emission.
module bspline_basis_evaluator_unit #(
    parameter int MAX_ORDER  = 16,
    parameter int MAX_BREAKS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] break_index, [39:8] value
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [8:0] basis_index, [40:9] basis_value, rest zero
    output logic [0:0]  m_tuser,   // [0] overflow
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata
);
    import bsbe_pkg::*;

    localparam int BW = (MAX_BREAKS > 1) ? $clog2(MAX_BREAKS) : 1;
    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int QW = $clog2(MAX_BREAKS + 2 * MAX_ORDER + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LAST_RD, S_LAST_CHK, S_SRCH_RD, S_SRCH_CHK, S_INIT,
        S_TRI_RD1, S_TRI_RD2, S_TRI_RD3, S_TRI_DEN, S_TRI_DIV,
        S_TRI_M1, S_TRI_M2, S_TRI_M3,
        S_DER_RD1, S_DER_RD2, S_DER_DEN, S_DER_DIV, S_EMIT
    } state_t;

    state_t           state_reg;
    logic [4:0]       order_reg;
    logic [3:0]       deriv_reg;
    logic [8:0]       nbrk_reg;
    logic [QW-1:0]    ptr_reg;
    logic [QW-1:0]    left_reg;
    fix_t             x_reg;
    logic             ovf_reg;
    logic             dzero_reg;
    logic [4:0]       i_reg;
    logic [4:0]       j_reg;
    logic [4:0]       r_reg;
    fix_t             saved_reg;
    fix_t             tmp_reg;
    fix_t             term_reg;
    fix_t             rdiff_reg [MAX_ORDER];
    fix_t             ldiff_reg [MAX_ORDER];
    fix_t             bw_reg    [MAX_ORDER];
    logic signed [2*VW-1:0] prod_reg;

    fix_t             break_mem [MAX_BREAKS];
    fix_t             rdata_reg;
    logic [BW-1:0]    raddr;
    logic             mem_we;

    logic [4:0]       k;
    logic [4:0]       k_new;
    logic [QW-1:0]    nb;
    logic [QW-1:0]    nbasis;
    logic [4:0]       lo;
    logic [AW-1:0]    ii;
    logic [AW-1:0]    jmi;
    logic [4:0]       jp1;
    sat_t             den_tri;
    sat_t             den_der;
    sat_t             rsc;
    sat_t             mul_rnd;
    sat_t             acc_tri;
    sat_t             acc_der;
    sat_t             rd_sub;
    sat_t             ld_sub;
    fix_t             mul_a;
    fix_t             mul_b;
    logic             div_start;
    fix_t             div_num;
    fix_t             div_den;
    div_res_t         div_res;
    logic             s_acc;
    logic             out_free;
    logic [15:0]      col;

    function automatic logic [4:0] clamp_order(input logic [4:0] v);
        if (v == 5'd0)
            return 5'd1;
        if (32'(v) > MAX_ORDER)
            return 5'(MAX_ORDER);
        return v;
    endfunction

    // Store address of knot q in the clamped knot sequence.
    function automatic logic [BW-1:0] kaddr(input logic [QW-1:0] q, input logic [4:0] kk,
                                            input logic [QW-1:0] nbk, input logic [QW-1:0] nba);
        if (q < QW'(kk))
            return '0;
        if (q < nba)
            return BW'(q - QW'(kk) + QW'(1));
        return BW'(nbk - QW'(1));
    endfunction

    assign k      = clamp_order(order_reg);
    assign k_new  = (cfg_addr == CFG_ORDER) ? clamp_order(cfg_wdata[4:0]) : k;
    assign nb     = (nbrk_reg < 9'd2) ? QW'(2) :
                    ((32'(nbrk_reg) > MAX_BREAKS) ? QW'(MAX_BREAKS) : QW'(nbrk_reg));
    assign nbasis = nb + QW'(k) - QW'(2);
    assign lo     = k - 5'(deriv_reg);
    assign ii     = i_reg[AW-1:0];
    assign jmi    = j_reg[AW-1:0] - i_reg[AW-1:0];
    assign jp1    = j_reg + 5'd1;
    assign s_acc  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid || m_tready;
    assign mem_we = s_acc && (s_tuser[0] == CMD_WRITE) && (32'(s_tdata[7:0]) < MAX_BREAKS);

    always_comb begin
        den_tri = fadd(rdiff_reg[ii], ldiff_reg[jmi]);
        den_der = fsub(tmp_reg, rdata_reg);
        rd_sub  = fsub(rdata_reg, x_reg);
        ld_sub  = fsub(x_reg, rdata_reg);
        rsc     = sat_wide(wide_t'($signed({1'b0, r_reg})) * wide_t'(bw_reg[ii]));
        mul_rnd = sat_wide((wide_t'(prod_reg) + HALF_W) >>> FB);
        acc_tri = fadd(saved_reg, mul_rnd.val);
        acc_der = fsub(saved_reg, div_res.quo);
        col     = 16'(left_reg) - 16'(k) + 16'd1 + 16'(i_reg);
    end

    always_comb begin
        unique case (state_reg)
            S_LAST_RD: raddr = BW'(nb - QW'(1));
            S_SRCH_RD: raddr = kaddr(left_reg + QW'(1), k, nb, nbasis);
            S_TRI_RD1: raddr = kaddr(left_reg + QW'(j_reg) + QW'(1), k, nb, nbasis);
            S_TRI_RD2: raddr = kaddr(left_reg - QW'(j_reg), k, nb, nbasis);
            S_DER_RD1: raddr = kaddr(left_reg + QW'(1) + QW'(i_reg), k, nb, nbasis);
            S_DER_RD2: raddr = kaddr(left_reg - QW'(r_reg) + QW'(1) + QW'(i_reg),
                                     k, nb, nbasis);
            default:   raddr = '0;
        endcase
    end

    always_comb begin
        div_start = (state_reg == S_TRI_DEN) || (state_reg == S_DER_DEN);
        div_num   = (state_reg == S_TRI_DEN) ? bw_reg[ii] : rsc.val;
        div_den   = (state_reg == S_TRI_DEN) ? den_tri.val : den_der.val;
        mul_a     = (state_reg == S_TRI_M2) ? ldiff_reg[jmi] : term_reg;
        mul_b     = (state_reg == S_TRI_M2) ? term_reg : rdiff_reg[ii];
    end

    bsbe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    always_ff @(posedge aclk) begin
        if (mem_we)
            break_mem[BW'(s_tdata[7:0])] <= fix_t'(s_tdata[39:8]);
        rdata_reg <= break_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            order_reg <= 5'd4;
            deriv_reg <= 4'd0;
            nbrk_reg  <= 9'd2;
            ptr_reg   <= QW'(3);
            ovf_reg   <= 1'b0;
            dzero_reg <= 1'b0;
            m_tvalid  <= 1'b0;
        end else begin
            // Emission sets the valid flag itself whenever the output register is free.
            if (m_tvalid && m_tready && state_reg != S_EMIT)
                m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser[0] == CMD_EVAL) begin
                            x_reg   <= fix_t'(s_tdata[39:8]);
                            ovf_reg <= 1'b0;
                            if (ptr_reg < QW'(k) - QW'(1) || ptr_reg > nbasis - QW'(1))
                                left_reg <= QW'(k) - QW'(1);
                            else
                                left_reg <= ptr_reg;
                            state_reg <= S_LAST_RD;
                        end else if (mem_we && !cfg_we) begin
                            ptr_reg <= QW'(k) - QW'(1);
                        end
                    end
                    if (cfg_we) begin
                        unique case (cfg_addr)
                            CFG_ORDER: order_reg <= cfg_wdata[4:0];
                            CFG_DERIV: deriv_reg <= cfg_wdata[3:0];
                            CFG_NBRK:  nbrk_reg  <= cfg_wdata;
                            default:   ;
                        endcase
                        if (cfg_addr == CFG_ORDER || cfg_addr == CFG_DERIV ||
                            cfg_addr == CFG_NBRK)
                            ptr_reg <= QW'(k_new) - QW'(1);
                    end
                end
                S_LAST_RD: state_reg <= S_LAST_CHK;
                S_LAST_CHK: begin
                    if (x_reg >= rdata_reg) begin
                        left_reg  <= nbasis - QW'(1);
                        state_reg <= S_INIT;
                    end else begin
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    state_reg <= (left_reg < nbasis - QW'(1)) ? S_SRCH_CHK : S_INIT;
                end
                S_SRCH_CHK: begin
                    if (rdata_reg <= x_reg) begin
                        left_reg  <= left_reg + QW'(1);
                        state_reg <= S_SRCH_RD;
                    end else begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT: begin
                    ptr_reg   <= left_reg;
                    bw_reg[0] <= FIX_ONE;
                    j_reg     <= 5'd0;
                    i_reg     <= 5'd0;
                    r_reg     <= lo;
                    saved_reg <= '0;
                    if (5'(deriv_reg) >= k) begin
                        dzero_reg <= 1'b1;
                        state_reg <= S_EMIT;
                    end else begin
                        dzero_reg <= 1'b0;
                        if (lo >= 5'd2)
                            state_reg <= S_TRI_RD1;
                        else
                            state_reg <= (lo < k) ? S_DER_RD1 : S_EMIT;
                    end
                end
                S_TRI_RD1: state_reg <= S_TRI_RD2;
                S_TRI_RD2: begin
                    rdiff_reg[j_reg[AW-1:0]] <= rd_sub.val;
                    ovf_reg   <= ovf_reg | rd_sub.ovf;
                    state_reg <= S_TRI_RD3;
                end
                S_TRI_RD3: begin
                    ldiff_reg[j_reg[AW-1:0]] <= ld_sub.val;
                    ovf_reg   <= ovf_reg | ld_sub.ovf;
                    i_reg     <= 5'd0;
                    saved_reg <= '0;
                    state_reg <= S_TRI_DEN;
                end
                S_TRI_DEN: begin
                    ovf_reg   <= ovf_reg | den_tri.ovf;
                    state_reg <= S_TRI_DIV;
                end
                S_TRI_DIV: begin
                    if (div_res.done) begin
                        term_reg  <= div_res.quo;
                        ovf_reg   <= ovf_reg | div_res.ovf;
                        state_reg <= S_TRI_M1;
                    end
                end
                S_TRI_M1: state_reg <= S_TRI_M2;
                S_TRI_M2: begin
                    bw_reg[ii] <= acc_tri.val;
                    ovf_reg    <= ovf_reg | mul_rnd.ovf | acc_tri.ovf;
                    state_reg  <= S_TRI_M3;
                end
                S_TRI_M3: begin
                    ovf_reg <= ovf_reg | mul_rnd.ovf;
                    if (i_reg == j_reg) begin
                        bw_reg[jp1[AW-1:0]] <= mul_rnd.val;
                        j_reg <= jp1;
                        if (jp1 + 5'd1 < lo) begin
                            state_reg <= S_TRI_RD1;
                        end else begin
                            r_reg     <= lo;
                            i_reg     <= 5'd0;
                            saved_reg <= '0;
                            state_reg <= (lo < k) ? S_DER_RD1 : S_EMIT;
                        end
                    end else begin
                        i_reg     <= i_reg + 5'd1;
                        saved_reg <= mul_rnd.val;
                        state_reg <= S_TRI_DEN;
                    end
                end
                S_DER_RD1: state_reg <= S_DER_RD2;
                S_DER_RD2: begin
                    tmp_reg   <= rdata_reg;
                    state_reg <= S_DER_DEN;
                end
                S_DER_DEN: begin
                    ovf_reg   <= ovf_reg | den_der.ovf | rsc.ovf;
                    state_reg <= S_DER_DIV;
                end
                S_DER_DIV: begin
                    if (div_res.done) begin
                        bw_reg[ii] <= acc_der.val;
                        ovf_reg    <= ovf_reg | div_res.ovf | acc_der.ovf;
                        if (i_reg + 5'd1 == r_reg) begin
                            // The last quotient of a step becomes the new top entry.
                            bw_reg[r_reg[AW-1:0]] <= div_res.quo;
                            r_reg     <= r_reg + 5'd1;
                            i_reg     <= 5'd0;
                            saved_reg <= '0;
                            state_reg <= (r_reg + 5'd1 == k) ? S_EMIT : S_DER_RD1;
                        end else begin
                            saved_reg <= div_res.quo;
                            i_reg     <= i_reg + 5'd1;
                            state_reg <= S_DER_RD1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= {7'd0, (dzero_reg ? fix_t'(0) : bw_reg[ii]), col[8:0]};
                        m_tuser  <= ovf_reg;
                        m_tlast  <= (i_reg + 5'd1 == k);
                        if (i_reg + 5'd1 == k)
                            state_reg <= S_IDLE;
                        else
                            i_reg <= i_reg + 5'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/bsbe_div.sv
// Iterative fixed-point divider, one quotient bit per cycle: (num * 2^FB) / den.
// Depends on bsbe_pkg for the value types and the saturation helper.
module bsbe_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  bsbe_pkg::fix_t    num,
    input  bsbe_pkg::fix_t    den,
    output bsbe_pkg::div_res_t res
);
    import bsbe_pkg::*;

    localparam int NW = VW + FB;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic          zero_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] sh_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] dmag_reg;
    logic [VW:0]   rem_shift;
    logic          fits;
    logic [VW-1:0] num_mag;
    logic [VW-1:0] den_mag;
    wide_t         q_signed;
    sat_t          q_sat;

    assign num_mag   = num[VW-1] ? VW'(-num) : VW'(num);
    assign den_mag   = den[VW-1] ? VW'(-den) : VW'(den);
    assign rem_shift = {rem_reg[VW-1:0], sh_reg[NW-1]};
    assign fits      = rem_shift >= {1'b0, dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg  <= num[VW-1] ^ den[VW-1];
                sh_reg   <= {num_mag, {FB{1'b0}}};
                dmag_reg <= den_mag;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                zero_reg <= (den == '0);
                busy_reg <= (den != '0);
                done_reg <= (den == '0);
            end else if (busy_reg) begin
                sh_reg  <= {sh_reg[NW-2:0], fits};
                rem_reg <= fits ? rem_shift - {1'b0, dmag_reg} : rem_shift;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        q_signed = neg_reg ? -wide_t'(sh_reg) : wide_t'(sh_reg);
        q_sat    = sat_wide(q_signed);
        res.done = done_reg;
        res.ovf  = zero_reg ? 1'b1 : q_sat.ovf;
        res.quo  = zero_reg ? '0 : q_sat.val;
    end

endmodule

### hdl/bsbe_checker.sv
// Port-level checks for the B-spline basis evaluator, bound to the top level.
// Depends only on the top level's ports.
module bsbe_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result word keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

    // No new item is taken while a point still has words to deliver.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted in the middle of a point");

    // Words of one point carry consecutive columns.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
            m_tdata[8:0] == $past(m_tdata[8:0]) + 9'd1)
    else $error("column indices not consecutive");

    // The overflow flag is the same on every word of a point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |-> m_tuser == $past(m_tuser))
    else $error("overflow flag changed within a point");

endmodule

bind bspline_basis_evaluator_unit bsbe_port_checks u_bsbe_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/bsbe_checker.sv
`timescale 1ns / 100ps
// Result checker for the B-spline basis evaluator: watches the input, result and register ports,
// predicts every basis word and compares it. Depends on bsbe_pkg.
module bsbe_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] break_index, [39:8] value
    input  logic [0:0]  s_tuser,   // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [8:0] basis_index, [40:9] basis_value
    input  logic [0:0]  m_tuser,   // [0] overflow
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata,
    output int          pending,
    output int          fails
);
    import bsbe_pkg::*;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct packed {
        logic [8:0] col;
        fix_t       val;
        logic       ovf;
        logic       last;
    } basis_word_t;

    basis_word_t basis_expected[$];
    longint      break_vals[256];
    longint      rdiff[16];
    longint      ldiff[16];
    longint      work[16];
    int          order_reg;
    int          deriv_reg;
    int          count_reg;
    int          span_ptr;
    bit          sat_hit;

    function automatic int eff_order();
        return (order_reg < 1) ? 1 : (order_reg > 16) ? 16 : order_reg;
    endfunction

    function automatic int eff_breaks();
        return (count_reg < 2) ? 2 : (count_reg > 256) ? 256 : count_reg;
    endfunction

    function longint clip(input longint v);
        if (v > VMAX) begin
            sat_hit = 1'b1;
            return VMAX;
        end
        if (v < VMIN) begin
            sat_hit = 1'b1;
            return VMIN;
        end
        return v;
    endfunction

    function longint qmul(input longint a, input longint b);
        return clip((a * b + 64'sd32768) >>> 16);
    endfunction

    function longint qdiv(input longint a, input longint b);
        if (b == 0) begin
            sat_hit = 1'b1;
            return 0;
        end
        return clip((a * 64'sd65536) / b);
    endfunction

    // Clamped knot sequence: end breaks repeated order times.
    function automatic longint knot(input int q, input int k, input int nb);
        if (q < k) return break_vals[0];
        if (q < nb + k - 2) return break_vals[q - k + 1];
        return break_vals[nb - 1];
    endfunction

    task automatic predict_point(input longint x);
        int k, nb, d, nbasis, left, lo;
        longint saved, term, den;
        basis_word_t w;
        k = eff_order();
        nb = eff_breaks();
        d = deriv_reg;
        nbasis = nb + k - 2;
        sat_hit = 1'b0;
        left = span_ptr;
        if (left < k - 1 || left > nbasis - 1) left = k - 1;
        if (x >= break_vals[nb - 1]) begin
            left = nbasis - 1;
        end else begin
            while (left < nbasis - 1 && knot(left + 1, k, nb) <= x) left++;
        end
        span_ptr = left;
        for (int i = 0; i < 16; i++) work[i] = 0;
        if (d < k) begin
            lo = k - d;
            work[0] = 64'sd65536;
            for (int j = 0; j + 1 < lo; j++) begin
                rdiff[j] = clip(knot(left + j + 1, k, nb) - x);
                ldiff[j] = clip(x - knot(left - j, k, nb));
                saved = 0;
                for (int i = 0; i <= j; i++) begin
                    den = clip(rdiff[i] + ldiff[j - i]);
                    term = qdiv(work[i], den);
                    work[i] = clip(saved + qmul(term, rdiff[i]));
                    saved = qmul(ldiff[j - i], term);
                end
                work[j + 1] = saved;
            end
            // Derivative steps lift the order back up to k.
            for (int r = lo; r < k; r++) begin
                saved = 0;
                for (int i = 0; i < r; i++) begin
                    den = clip(knot(left + 1 + i, k, nb) - knot(left - r + 1 + i, k, nb));
                    term = qdiv(clip(longint'(r) * work[i]), den);
                    work[i] = clip(saved - term);
                    saved = term;
                end
                work[r] = saved;
            end
        end
        for (int j = 0; j < k; j++) begin
            w.col = 9'(left - k + 1 + j);
            w.val = fix_t'(work[j]);
            w.ovf = sat_hit;
            w.last = (j == k - 1);
            basis_expected.push_back(w);
        end
    endtask

    initial begin
        fails = 0;
        pending = 0;
        order_reg = 4;
        deriv_reg = 0;
        count_reg = 2;
        span_ptr = 3;
        for (int i = 0; i < 256; i++) break_vals[i] = 0;
    end

    always @(posedge aclk) begin
        basis_word_t got, want;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_addr == CFG_ORDER) order_reg = cfg_wdata[4:0];
                else if (cfg_addr == CFG_DERIV) deriv_reg = cfg_wdata[3:0];
                else if (cfg_addr == CFG_NBRK) count_reg = cfg_wdata;
                if (cfg_addr == CFG_ORDER || cfg_addr == CFG_DERIV || cfg_addr == CFG_NBRK)
                    span_ptr = eff_order() - 1;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == CMD_WRITE) begin
                    break_vals[s_tdata[7:0]] = longint'($signed(s_tdata[39:8]));
                    span_ptr = eff_order() - 1;
                end else begin
                    predict_point(longint'($signed(s_tdata[39:8])));
                end
            end
            if (m_tvalid && m_tready) begin
                got.col = m_tdata[8:0];
                got.val = m_tdata[40:9];
                got.ovf = m_tuser[0];
                got.last = m_tlast;
                if (basis_expected.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected basis word: %p", got);
                end else begin
                    want = basis_expected.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"basis word mismatch: expected col %0d val %0d ",
                                      "ovf %0b last %0b, got col %0d val %0d ovf %0b ",
                                      "last %0b"},
                                     want.col, want.val, want.ovf, want.last,
                                     got.col, got.val, got.ovf, got.last);
                    end
                end
            end
        end
        pending = basis_expected.size();
    end

endmodule

### tb/bspline_basis_evaluator_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the B-spline basis evaluator: clock, reset, stimulus and verdict.
// Depends on bsbe_pkg, bspline_basis_evaluator_unit and bsbe_checker.
module bspline_basis_evaluator_unit_test;
    import bsbe_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [8:0]  cfg_wdata = '0;
    int          pending;
    int          fails;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          quiet_cycles = 0;
    int          points_sent = 0;
    longint      bk[256];

    always #10 aclk = ~aclk;

    bspline_basis_evaluator_unit i_dut (.*);

    bsbe_checker i_checker (.*);

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_stall);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input logic cmd, input logic [7:0] idx, input longint val);
        if ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {val[31:0], idx};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_EVAL) points_sent++;
    endtask

    // Lets every expected word drain, plus time for a trailing break write.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (50) @(posedge aclk);
    endtask

    // The caller drops the write enable after its last register write.
    task automatic write_reg(input logic [1:0] addr, input int val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= 9'(val);
        @(posedge aclk);
    endtask

    task automatic run_phase(input int k, input int d, input int nb, input int npts,
                             input int mode);
        int n;
        longint span, cur, x;
        n = (nb < 2) ? 2 : (nb > 256) ? 256 : nb;
        drain();
        send_idle = (mode == 1) ? 82 : (mode == 3) ? 19 : 0;
        recv_stall = (mode == 2) ? 82 : (mode == 3) ? 19 : 0;
        write_reg(CFG_ORDER, k);
        write_reg(CFG_DERIV, d);
        write_reg(CFG_NBRK, nb);
        cfg_we <= 1'b0;
        // Mostly increasing breaks; short sets sometimes get a repeat or a huge step.
        bk[0] = longint'($urandom_range(0, 2097152)) - 1048576;
        for (int i = 1; i < n; i++) begin
            case ((n <= 16) ? $urandom_range(0, 7) : 7)
                0: bk[i] = bk[i - 1];
                1: bk[i] = bk[i - 1] + 16777216;
                default: bk[i] = bk[i - 1] + $urandom_range(1, 262144);
            endcase
        end
        for (int i = 0; i < n; i++) send_word(CMD_WRITE, 8'(i), bk[i]);
        span = bk[n - 1] - bk[0];
        cur = bk[0] - $urandom_range(0, 131072);
        for (int p = 0; p < npts; p++) begin
            case ($urandom_range(0, 9))
                0: x = longint'($signed($urandom()));
                1: x = cur - $urandom_range(0, 65536);
                2: begin
                    x = cur;
                    send_word(CMD_WRITE, 8'($urandom_range(0, n - 1)), bk[0]);
                    send_word(CMD_WRITE, 8'(0), bk[0]);
                end
                default: x = cur;
            endcase
            send_word(CMD_EVAL, 8'($urandom()), x);
            cur += $urandom_range(0, int'(span / npts) * 2 + 1);
        end
    endtask

    initial begin
        longint mid;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // The reset break count uses the first two store entries only.
        for (int i = 0; i < 2; i++) begin
            bk[i] = (longint'(i) - 128) * 1048576 + $urandom_range(0, 65535);
            send_word(CMD_WRITE, 8'(i), bk[i]);
        end
        // Reset settings: cubic, value, two breaks.
        mid = (bk[0] + bk[1]) / 2;
        send_word(CMD_EVAL, 8'hFF, -64'sd2147483648);
        send_word(CMD_EVAL, 8'h00, bk[0] - 1);
        send_word(CMD_EVAL, 8'h00, bk[0]);
        send_word(CMD_EVAL, 8'h00, mid);
        send_word(CMD_EVAL, 8'h00, bk[0]);
        send_word(CMD_EVAL, 8'h00, bk[1] - 1);
        send_word(CMD_EVAL, 8'h00, bk[1]);
        send_word(CMD_EVAL, 8'h00, 64'sd2147483647);
        run_phase(1, 0, 2, 6, 0);
        run_phase(16, 15, 20, 4, 1);
        run_phase(16, 0, 3, 3, 2);
        run_phase(0, 0, 0, 6, 3);
        run_phase(2, 5, 17, 6, 0);
        run_phase(4, 3, 6, 8, 1);
        run_phase(31, 1, 1, 3, 2);
        for (int ph = 0; points_sent < 70; ph++) begin
            int k;
            k = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 16);
            run_phase(k, $urandom_range(0, k), $urandom_range(2, 12),
                      (k > 8) ? 4 : $urandom_range(8, 16), ph % 5);
        end
        drain();
        repeat (500) @(posedge aclk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
